### hdl/esb_pkg.sv
// Shared types and constants of the electrode selection box encoder.
package esb_pkg;

  localparam int MAX_COLS     = 32;
  localparam int ROW_BITS     = 10;
  localparam int SHANK_BITS   = 3;
  localparam int COL_BITS     = $clog2(MAX_COLS);
  localparam int CNT_BITS     = COL_BITS + 1;
  localparam int HGT_BITS     = ROW_BITS + 1;
  localparam int NBOX         = 3;
  localparam int BIDX_BITS    = $clog2(NBOX);
  localparam int QDEPTH       = 4;
  localparam int QPTR_BITS    = $clog2(QDEPTH);
  localparam int QCNT_BITS    = $clog2(QDEPTH + 1);
  localparam int MAX_RESULTS  = 32;
  localparam int RES_CNT_BITS = $clog2(MAX_RESULTS);
  localparam logic [CNT_BITS-1:0] COL_COUNT_RESET = CNT_BITS'(4);

  typedef struct packed {
    logic [SHANK_BITS-1:0] shank;
    logic [ROW_BITS-1:0]   row;
    logic [COL_BITS-1:0]   column;
    logic                  last_entry;
  } in_item_t;

  typedef struct packed {
    logic [SHANK_BITS-1:0] box_shank_out;
    logic [ROW_BITS-1:0]   row_first;
    logic [HGT_BITS-1:0]   row_end;
    logic [COL_BITS-1:0]   col_first;
    logic [CNT_BITS-1:0]   col_end;
    logic                  last_result;
  } out_item_t;

  // A closed box as handed to the run emitter; pattern already limited to col_count.
  typedef struct packed {
    logic [SHANK_BITS-1:0] shank;
    logic [ROW_BITS-1:0]   row_first;
    logic [HGT_BITS-1:0]   row_end;
    logic [MAX_COLS-1:0]   pattern;
  } box_t;

  // All boxes closed by one input item, in emission order (index 0 first).
  typedef struct packed {
    box_t [NBOX-1:0] boxes;
  } step_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [SHANK_BITS-1:0] shank;
    logic [ROW_BITS-1:0]   row;
    logic [HGT_BITS-1:0]   height;
    logic [MAX_COLS-1:0]   pattern;
    logic                  valid;
  } open_box_t;

  typedef struct packed {
    logic [SHANK_BITS-1:0] shank;
    logic [ROW_BITS-1:0]   index;
    logic [MAX_COLS-1:0]   pattern;
    logic                  valid;
  } pend_row_t;

endpackage

### hdl/esb_front.sv
// Front end: row merging, box extension and box closing for each accepted entry.
module esb_front import esb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  in_item_t            item,
  input  logic [MAX_COLS-1:0] col_mask,
  output logic                push,
  output step_t               step
);

  open_box_t ob, ob_next;
  pend_row_t pr, pr_next;

  function automatic logic row_extends(open_box_t o, pend_row_t p);
    logic [ROW_BITS+1:0] top;
    top = {2'b00, o.row} + {1'b0, o.height};
    return o.valid && (p.shank == o.shank) && ({2'b00, p.index} == top) &&
           (p.pattern == o.pattern);
  endfunction

  function automatic box_t close_box(open_box_t o, logic [MAX_COLS-1:0] mask);
    box_t                b;
    logic [ROW_BITS+1:0] top;
    top         = {2'b00, o.row} + {1'b0, o.height};
    b.shank     = o.shank;
    b.row_first = o.row;
    b.row_end   = top[HGT_BITS-1:0];
    b.pattern   = o.pattern & mask;
    return b;
  endfunction

  function automatic open_box_t start_box(pend_row_t p);
    open_box_t o;
    o.shank   = p.shank;
    o.row     = p.index;
    o.height  = HGT_BITS'(1);
    o.pattern = p.pattern;
    o.valid   = 1'b1;
    return o;
  endfunction

  logic [MAX_COLS-1:0] col_bit;
  logic                same_row;
  open_box_t           ob1;
  pend_row_t           pr1;
  box_t                box_a, box_b, box_c;

  always_comb begin
    col_bit  = MAX_COLS'(1) << item.column;
    same_row = pr.valid && (pr.shank == item.shank) && (pr.index == item.row);
    box_a    = '0;
    box_b    = '0;
    box_c    = '0;

    // A new row completes the pending one.
    ob1 = ob;
    if (!same_row && pr.valid) begin
      if (row_extends(ob, pr)) begin
        ob1.height = ob.height + HGT_BITS'(1);
      end else begin
        if (ob.valid) box_a = close_box(ob, col_mask);
        ob1 = start_box(pr);
      end
    end
    if (same_row) begin
      pr1         = pr;
      pr1.pattern = pr.pattern | col_bit;
    end else begin
      pr1.shank   = item.shank;
      pr1.index   = item.row;
      pr1.pattern = col_bit;
      pr1.valid   = 1'b1;
    end

    // Last entry: complete the row, then flush the open box.
    ob_next = ob1;
    pr_next = pr1;
    if (item.last_entry) begin
      if (row_extends(ob1, pr1)) begin
        ob_next.height = ob1.height + HGT_BITS'(1);
      end else begin
        if (ob1.valid) box_b = close_box(ob1, col_mask);
        ob_next = start_box(pr1);
      end
      box_c         = close_box(ob_next, col_mask);
      ob_next.valid = 1'b0;
      pr_next.valid = 1'b0;
    end

    step.boxes[0] = box_a;
    step.boxes[1] = box_b;
    step.boxes[2] = box_c;
    // Boxes without any run in range produce nothing; queue only steps with output.
    push = accept && ((|box_a.pattern) || (|box_b.pattern) || (|box_c.pattern));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob <= '0;
      pr <= '0;
    end else if (accept) begin
      ob <= ob_next;
      pr <= pr_next;
    end
  end

endmodule

### hdl/esb_queue.sv
// Short queue of closed-box steps between the front and back ends.
module esb_queue import esb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  step_t   wr_step,
  input  logic    pop,
  output step_t   head,
  output q_stat_t stat
);

  step_t                mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == QCNT_BITS'(QDEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      if (push && !pop)      count <= count + QCNT_BITS'(1);
      else if (pop && !push) count <= count - QCNT_BITS'(1);
    end
  end

endmodule

### hdl/esb_back.sv
// Back end: split each queued box into column runs, one result per cycle while out_stall is low.
module esb_back import esb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  step_t     head,
  input  logic      q_empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  function automatic logic [COL_BITS-1:0] lsb_index(logic [MAX_COLS-1:0] v);
    logic [COL_BITS-1:0] idx;
    idx = '0;
    for (int i = MAX_COLS - 1; i >= 0; i--) begin
      if (v[i]) idx = COL_BITS'(i);
    end
    return idx;
  endfunction

  function automatic logic [COL_BITS-1:0] msb_index(logic [MAX_COLS-1:0] v);
    logic [COL_BITS-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (v[i]) idx = COL_BITS'(i);
    end
    return idx;
  endfunction

  logic                    active;
  logic [BIDX_BITS-1:0]    bidx;
  logic [MAX_COLS-1:0]     rem;
  logic [RES_CNT_BITS-1:0] cnt;

  logic [NBOX-1:0]      nz;
  logic [BIDX_BITS-1:0] first_b, cur_b, next_b;
  logic                 later;
  logic [MAX_COLS-1:0]  cur_rem, low, after, run;
  logic [MAX_COLS:0]    sum;
  logic                 last_res, fire;
  box_t                 cur_box;

  always_comb begin
    for (int i = 0; i < NBOX; i++) nz[i] = |head.boxes[i].pattern;
    first_b = '0;
    for (int i = NBOX - 1; i >= 0; i--) begin
      if (nz[i]) first_b = BIDX_BITS'(i);
    end
    cur_b   = active ? bidx : first_b;
    cur_box = head.boxes[cur_b];
    cur_rem = active ? rem : cur_box.pattern;

    // Adding the lowest set bit ripples through the lowest run and clears it.
    low   = cur_rem & (~cur_rem + MAX_COLS'(1));
    sum   = {1'b0, cur_rem} + {1'b0, low};
    after = cur_rem & sum[MAX_COLS-1:0];
    run   = cur_rem & ~sum[MAX_COLS-1:0];

    later  = 1'b0;
    next_b = cur_b;
    for (int i = NBOX - 1; i >= 0; i--) begin
      if ((BIDX_BITS'(i) > cur_b) && nz[i]) begin
        later  = 1'b1;
        next_b = BIDX_BITS'(i);
      end
    end

    // Results of one step are capped; the cap ends the step.
    last_res = ((after == '0) && !later) || (cnt == RES_CNT_BITS'(MAX_RESULTS - 1));
    fire     = !q_empty && (!out_valid || !out_stall);
    pop      = fire && last_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      bidx      <= '0;
      rem       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        if (last_res) begin
          active <= 1'b0;
          cnt    <= '0;
        end else begin
          active <= 1'b1;
          cnt    <= cnt + RES_CNT_BITS'(1);
          if (after == '0) begin
            bidx <= next_b;
            rem  <= head.boxes[next_b].pattern;
          end else begin
            bidx <= cur_b;
            rem  <= after;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.box_shank_out <= cur_box.shank;
      out_data.row_first     <= cur_box.row_first;
      out_data.row_end       <= cur_box.row_end;
      out_data.col_first     <= lsb_index(cur_rem);
      out_data.col_end       <= {1'b0, msb_index(run)} + CNT_BITS'(1);
      out_data.last_result   <= last_res;
    end
  end

endmodule

### hdl/electrode_selection_box_encoder_core.sv
// Top level of the electrode selection box encoder: config register, front, queue, back.
//
// Sorted electrode entries (shank, row, column) are accepted one per cycle while the
// four-step queue has room. The front end ORs the entries of a row into a column
// pattern, extends the open box with identical rows directly above it and closes it
// otherwise; each entry closes up to three boxes (the last_entry flush included),
// and a step with at least one run in range is queued as a whole. The back end
// takes the lowest remaining run of the current box each cycle unless out_stall
// holds it, one result per run; entries that close nothing in range never reach
// the back end. The first result of an entry passes through the queue memory and
// then the output register. At most 32 results follow one entry, and the one that ends
// the entry carries last_result. in_stall rises only when the queue is full, which
// happens when boxes close faster than their runs drain. col_count (reset 4) limits
// the columns split into runs; values above 32 act as 32 and zero yields no runs.
// Write it only while the block is idle. No clearing pass after reset.
module electrode_selection_box_encoder_core import esb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [CNT_BITS-1:0] cfg_wr_data
);

  logic [CNT_BITS-1:0] col_count;
  logic [MAX_COLS-1:0] col_mask;
  logic                in_xfer;
  logic                push;
  logic                pop;
  step_t               wr_step;
  step_t               head;
  q_stat_t             q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= COL_COUNT_RESET;
    end else if (cfg_wr_en) begin
      col_count <= cfg_wr_data;
    end
  end

  // Columns below col_count take part in runs; this saturates at MAX_COLS by itself.
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) col_mask[i] = (CNT_BITS'(i) < col_count);
  end

  // Hold input while the queue cannot take another step.
  assign in_stall = q_stat.full;
  assign in_xfer  = in_valid && !in_stall;

  esb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (in_xfer),
    .item     (in_data),
    .col_mask (col_mask),
    .push     (push),
    .step     (wr_step)
  );

  esb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_step (wr_step),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  esb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
